// File: rtl/spq_pkg.sv
// Types, constants and helpers for the sorted priority queue.
// No dependencies; used by every module under rtl.
`default_nettype none

package spq_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PRIO_W      = 16;
    localparam int unsigned TAG_W       = 32;
    localparam int unsigned OCC_W       = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                     used;
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } t_slot;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } t_cmd;

    typedef struct packed {
        logic                     out_valid;
        logic signed [PRIO_W-1:0] out_priority;
        logic [TAG_W-1:0]         out_tag;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_result;

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spq_pkg::t_cmd  i_cmd,
    input  wire spq_pkg::t_slot i_left,
    input  wire logic          i_left_after,
    input  wire spq_pkg::t_slot i_right,
    output spq_pkg::t_slot     o_slot,
    output logic               o_after
);

    spq_pkg::t_slot r_slot;
    spq_pkg::t_slot n_slot;

    // entry stays ahead of the new one: stored and not greater
    assign o_after = r_slot.used && ($signed(r_slot.prio) <= $signed(i_cmd.prio));
    assign o_slot  = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.deq) begin
            n_slot = i_right;
        end else if (i_cmd.enq) begin
            n_slot.used = r_slot.used | i_left.used;
            if (!o_after) begin
                if (i_left_after) begin
                    n_slot.prio = i_cmd.prio;
                    n_slot.tag  = i_cmd.tag;
                end else begin
                    n_slot.prio = i_left.prio;
                    n_slot.tag  = i_left.tag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.used <= 1'b0;
        end else begin
            r_slot.used <= n_slot.used;
        end
        r_slot.prio <= n_slot.prio;
        r_slot.tag  <= n_slot.tag;
    end

endmodule

`default_nettype wire

// File: rtl/spq_obuf.sv
// Result register with a skid stage so a request is taken while a result waits.
// Depends on spq_pkg.
`default_nettype none

module spq_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire spq_pkg::t_result i_res,
    input  wire logic             i_stall,
    output logic               o_valid,
    output spq_pkg::t_result   o_res,
    output logic               o_full
);

    logic               r_vld;
    logic               r_skid_vld;
    spq_pkg::t_result   r_data;
    spq_pkg::t_result   r_skid;
    logic               w_free;

    assign w_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_res   = r_data;
    assign o_full  = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_free) begin
            if (r_skid_vld) begin
                r_vld      <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_vld <= i_push;
            end
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_data <= r_skid_vld ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue_top.sv
// Sorted priority queue top: row of spq_cell slots, entry count and spq_obuf.
// Depends on spq_pkg, spq_cell, spq_obuf.
`default_nettype none

// Min-first stable priority queue of QUEUE_DEPTH entries held in a row of
// cells, front at cell 0. On enqueue every cell compares the incoming priority
// against its own entry and takes its own, its left neighbor's or the new
// entry; on dequeue it takes its right neighbor's. One request is accepted per
// clock while o_stall is low. Each result is registered in the output register,
// or in the skid register while it stalls; o_stall rises only once two results wait unread.
module sorted_priority_queue_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_operation,
    input  wire logic signed [15:0]          i_item_priority,
    input  wire logic [31:0]                 i_item_tag,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_out_valid,
    output logic signed [15:0]               o_out_priority,
    output logic [31:0]                      o_out_tag,
    output logic [1:0]                       o_status,
    output logic [4:0]                       o_occupancy
);

    localparam int unsigned N = spq_pkg::QUEUE_DEPTH;

    spq_pkg::t_slot             slots [N];
    logic [N-1:0]               after;
    logic [N-1:0]               used_vec;
    spq_pkg::t_cmd              cmd;
    spq_pkg::t_slot             c_head;
    spq_pkg::t_slot             c_tail;
    spq_pkg::t_result           res;
    spq_pkg::t_result           ob_res;
    logic [spq_pkg::CNT_W-1:0]  r_count;
    logic [spq_pkg::CNT_W-1:0]  n_count;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;
    logic                       ob_full;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = ob_full;
    assign w_full   = (r_count == spq_pkg::CNT_W'(N));
    assign w_empty  = (r_count == '0);

    assign cmd.enq  = w_accept && (i_operation == spq_pkg::OP_ENQ) && !w_full;
    assign cmd.deq  = w_accept && (i_operation == spq_pkg::OP_DEQ) && !w_empty;
    assign cmd.prio = i_item_priority;
    assign cmd.tag  = i_item_tag;

    assign c_head = '{used: 1'b1, prio: '0, tag: '0};
    assign c_tail = '{used: 1'b0, prio: '0, tag: '0};

    for (genvar k = 0; k < N; k++) begin : g_cell
        spq_pkg::t_slot left;
        spq_pkg::t_slot right;
        logic           left_after;
        if (k == 0) begin : g_first
            assign left       = c_head;
            assign left_after = 1'b1;
        end else begin : g_mid
            assign left       = slots[k-1];
            assign left_after = after[k-1];
        end
        if (k == N - 1) begin : g_last
            assign right = c_tail;
        end else begin : g_inner
            assign right = slots[k+1];
        end
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_left       (left),
            .i_left_after (left_after),
            .i_right      (right),
            .o_slot       (slots[k]),
            .o_after      (after[k])
        );
        assign used_vec[k] = slots[k].used;
    end

    always_comb begin
        n_count = r_count;
        if (cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (cmd.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        res              = '0;
        res.status       = spq_pkg::ST_OK;
        res.occupancy    = spq_pkg::occ_of(n_count);
        if (i_operation == spq_pkg::OP_DEQ) begin
            if (w_empty) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.out_valid    = 1'b1;
                res.out_priority = slots[0].prio;
                res.out_tag      = slots[0].tag;
            end
        end else if (w_full) begin
            res.status = spq_pkg::ST_FULL;
        end
    end

    spq_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (ob_res),
        .o_full  (ob_full)
    );

    assign o_out_valid    = ob_res.out_valid;
    assign o_out_priority = ob_res.out_priority;
    assign o_out_tag      = ob_res.out_tag;
    assign o_status       = ob_res.status;
    assign o_occupancy    = ob_res.occupancy;

    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(used_vec) == int'(r_count))
        else $error("entry count disagrees with used cells");

    a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((used_vec >> 1) & ~used_vec) == '0)
        else $error("used cells not contiguous from the front");

    a_front_dequeue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.deq |=> (o_valid && o_out_valid && o_status == spq_pkg::ST_OK)
                    || $past(ob_full) || $past(o_valid && i_stall))
        else $error("dequeue did not report an entry");

    a_skid_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid holds a result while the output register is empty");

    a_stable_sorted_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (used_vec[1] && used_vec[0]) |-> $signed(slots[0].prio) <= $signed(slots[1].prio))
        else $error("front cells out of order");

endmodule

`default_nettype wire

// File: tb/sorted_priority_queue_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue_top: directed and random enqueue and
// dequeue requests, each result checked against a sorted-list model of the queue.
// Depends on spq_pkg and the RTL under rtl.
module sorted_priority_queue_top_test;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1880;

    typedef struct {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    class spq_scoreboard;
        entry_t  sorted_entries[$];
        t_result pending_results[$];
        int mismatches;
        int checked;
        int enq_ok;
        int enq_full;
        int deq_hit;
        int deq_empty;

        function void note_request(input logic op, input logic signed [PRIO_W-1:0] prio,
                                   input logic [TAG_W-1:0] tag);
            t_result r;
            entry_t  e;
            int      pos;
            r = '0;
            r.status = ST_OK;
            if (op == OP_DEQ) begin
                if (sorted_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                    deq_empty++;
                end else begin
                    e = sorted_entries.pop_front();
                    r.out_valid    = 1'b1;
                    r.out_priority = e.prio;
                    r.out_tag      = e.tag;
                    deq_hit++;
                end
            end else if (sorted_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
                enq_full++;
            end else begin
                // stable: goes behind every entry of lower or equal priority
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio)
                    pos++;
                e.prio = prio;
                e.tag  = tag;
                sorted_entries.insert(pos, e);
                enq_ok++;
            end
            r.occupancy = OCC_W'(sorted_entries.size());
            pending_results.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request pending: valid=%0d prio=%0d tag=%h st=%0d occ=%0d",
                             $realtime, got.out_valid, got.out_priority, got.out_tag,
                             got.status, got.occupancy);
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.out_valid !== exp.out_valid || got.out_priority !== exp.out_priority ||
                got.out_tag !== exp.out_tag || got.status !== exp.status ||
                got.occupancy !== exp.occupancy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp valid=%0d prio=%0d tag=%h st=%0d occ=%0d, got valid=%0d prio=%0d tag=%h st=%0d occ=%0d",
                             $realtime, exp.out_valid, exp.out_priority, exp.out_tag,
                             exp.status, exp.occupancy, got.out_valid, got.out_priority,
                             got.out_tag, got.status, got.occupancy);
            end
        endfunction
    endclass

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_valid         = 1'b0;
    logic                     i_operation     = OP_ENQ;
    logic signed [PRIO_W-1:0] i_item_priority = '0;
    logic [TAG_W-1:0]         i_item_tag      = '0;
    logic                     i_stall         = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic                     o_out_valid;
    logic signed [PRIO_W-1:0] o_out_priority;
    logic [TAG_W-1:0]         o_out_tag;
    logic [1:0]               o_status;
    logic [OCC_W-1:0]         o_occupancy;

    spq_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;

    logic signed [PRIO_W-1:0] directed_prio [16] = '{
        -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd5, 16'sd5, 16'sd5,
        -16'sd32768, 16'sd32767, 16'sd0, -16'sd2, 16'sh5555, 16'shAAAA, 16'sd5, -16'sd1
    };

    sorted_priority_queue_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_item_priority (i_item_priority),
        .i_item_tag      (i_item_tag),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_valid     (o_out_valid),
        .o_out_priority  (o_out_priority),
        .o_out_tag       (o_out_tag),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic op, input logic signed [PRIO_W-1:0] prio,
                                input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_item_priority <= prio;
        i_item_tag      <= tag;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_request(op, prio, tag);
        @(negedge i_clk);
    endtask

    // Segments biased toward filling, draining or mixing, with tie-heavy or wide priorities.
    task automatic run_random(input int count);
        int left;
        int seg;
        int enq_pct;
        int prio_mode;
        logic op;
        logic signed [PRIO_W-1:0] p;
        left = count;
        while (left > 0) begin
            seg = $urandom_range(8, 40);
            case ($urandom_range(2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            prio_mode = $urandom_range(2);
            for (int k = 0; k < seg && left > 0; k++) begin
                op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
                case (prio_mode)
                    0: p = PRIO_W'($signed($urandom_range(7)) - 4);
                    1: p = PRIO_W'($urandom);
                    default: begin
                        case ($urandom_range(4))
                            0: p = -16'sd32768;
                            1: p = 16'sd32767;
                            2: p = 16'sd0;
                            3: p = -16'sd1;
                            default: p = PRIO_W'($urandom);
                        endcase
                    end
                endcase
                send_request(op, p, $urandom);
                left--;
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.out_valid    = o_out_valid;
            got.out_priority = o_out_priority;
            got.out_tag      = o_out_tag;
            got.status       = t_status'(o_status);
            got.occupancy    = o_occupancy;
            sb.check_result(got);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("sorted_priority_queue_top verification failed");
        $finish;
    end

    initial begin
        sb = new;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty dequeue, fill with extremes and ties, drop on full, partial drain
        send_request(OP_DEQ, '0, '0);
        for (int i = 0; i < 16; i++)
            send_request(OP_ENQ, directed_prio[i],
                         (i == 0) ? 32'h0000_0000 :
                         (i == 1) ? 32'hFFFF_FFFF : (32'hA5A5_0000 | i));
        send_request(OP_ENQ, 16'sd100, 32'h5A5A_5A5A);
        repeat (7) send_request(OP_DEQ, '0, $urandom);

        run_random(RANDOM_ITEMS / 4);
        tx_idle_pct  = 59;
        rx_stall_pct = 0;
        run_random(RANDOM_ITEMS / 4);
        tx_idle_pct  = 0;
        rx_stall_pct = 59;
        run_random(RANDOM_ITEMS / 4);
        tx_idle_pct  = 21;
        rx_stall_pct = 21;
        run_random(RANDOM_ITEMS / 4);
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d requests: %0d enqueued, %0d dropped on full, %0d dequeued, %0d dequeues on empty",
                 sb.enq_ok + sb.enq_full + sb.deq_hit + sb.deq_empty, sb.enq_ok, sb.enq_full,
                 sb.deq_hit, sb.deq_empty);
        $display("%0d results checked across four idle/stall mixes, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("sorted_priority_queue_top verification clean");
        else
            $display("sorted_priority_queue_top verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_obuf.sv
rtl/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_test.sv
